>>> design/phfe_pkg.sv
// shared types and constants of the packet header field extractor
`default_nettype none

package phfe_pkg;

   localparam int unsigned QueueDepth = 2;

   localparam logic [15:0] EthVlan  = 16'h8100;
   localparam logic [15:0] EthPppoe = 16'h8864;
   localparam logic [15:0] EthIpv4  = 16'h0800;
   localparam logic [15:0] PppIpv4  = 16'h0021;
   localparam logic [15:0] FragMask = 16'h3fff;
   localparam logic [7:0]  ProtoTcp = 8'd6;
   localparam logic [7:0]  ProtoUdp = 8'd17;

   localparam logic [2:0] DepthLink  = 3'd2;
   localparam logic [2:0] DepthNet   = 3'd3;
   localparam logic [2:0] DepthXport = 3'd4;

   localparam logic [1:0] RegParseDepth = 2'd0;
   localparam logic [1:0] RegHashEnable = 2'd1;

   localparam int unsigned RspWidth = 192;

   // raw header bytes captured from one frame
   typedef struct packed {
      logic [7:0]  byte_count;
      logic [15:0] type0;
      logic [11:0] tag;
      logic [15:0] type1;
      logic [15:0] ppp0;
      logic [15:0] ppp1;
      logic [3:0]  ihl;
      logic [15:0] frag;
      logic [7:0]  proto;
      logic [31:0] src;
      logic [31:0] dst;
      logic [15:0] sport;
      logic [15:0] dport;
      logic [3:0]  doff;
      logic [5:0]  flags;
   } rec_type;

   // decoded fields ahead of the hash adder
   typedef struct packed {
      logic [2:0]  depth;
      logic [15:0] etype;
      logic [11:0] vlan;
      logic [7:0]  proto;
      logic [31:0] src;
      logic [31:0] dst;
      logic [15:0] sport;
      logic [15:0] dport;
      logic [7:0]  l4;
      logic [7:0]  payload;
      logic [5:0]  flags;
      logic [17:0] small_sum;
      logic        hash_en;
   } dec_type;

endpackage

`default_nettype wire

>>> design/packet_header_field_extractor.sv
// top level of the packet header field extractor
`default_nettype none
// Frame bytes enter on the req_ stream, one byte per transaction, from the
// destination MAC onward; req_tlast marks the final byte of a frame. Every
// byte can be taken on consecutive cycles while the queue has room. Only
// the last byte of a frame yields a transaction on the rsp_ stream,
// carrying the Ethernet type, VLAN id, IPv4 protocol and addresses, ports,
// layer-4 and payload offsets, TCP flags, depth reached and flow hash.
// The front end captures header bytes by position as they stream by and,
// on the last byte, pushes one record into a short queue. The back end
// decodes a record in one stage and adds up the flow hash in a second, so
// a result passes from the queue through the decode and output registers
// to rsp_tvalid. Throughput is one byte per cycle and one result per cycle
// while rsp_tready holds; back to back one-byte frames run at full rate.
// When the receiver stalls, results wait in the output register, the
// decode stage and the queue; req_tready falls only when the queue is full.
// Reset clears the capture state, queue and pipeline and sets parse_depth
// to 4 and hash_enable to 1. The csr_ port holds these two registers at
// byte addresses 0 and 4.

module packet_header_field_extractor #(
   parameter int unsigned QUEUE_DEPTH = phfe_pkg::QueueDepth
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // packet_byte
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // depth_reached, ether_type, vlan_tag_id, ip_protocol, source_address,
   // dest_address, source_port, dest_port, transport_offset, payload_start,
   // tcp_flag_bits, flow_hash, zero fill
   output logic [phfe_pkg::RspWidth-1:0] rsp_tdata,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   logic [2:0] parse_depth_ff;
   logic       hash_enable_ff;
   logic       csr_wr;
   logic [1:0] csr_idx;
   logic       push, push_ready, head_valid, head_ready;
   phfe_pkg::rec_type push_rec, head;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = {1'b0, csr_paddr[2]};

   always_comb begin
      unique case (csr_idx)
         phfe_pkg::RegParseDepth: csr_prdata = {29'b0, parse_depth_ff};
         phfe_pkg::RegHashEnable: csr_prdata = {31'b0, hash_enable_ff};
         default:                 csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         parse_depth_ff <= phfe_pkg::DepthXport;
         hash_enable_ff <= 1'b1;
      end else if (csr_wr) begin
         unique case (csr_idx)
            phfe_pkg::RegParseDepth: parse_depth_ff <= csr_pwdata[2:0];
            phfe_pkg::RegHashEnable: hash_enable_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   phfe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .push       (push),
      .push_rec   (push_rec),
      .push_ready (push_ready)
   );

   phfe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push),
      .in_ready  (push_ready),
      .in_rec    (push_rec),
      .out_valid (head_valid),
      .out_ready (head_ready),
      .out_rec   (head)
   );

   phfe_back u_back (
      .clock       (clock),
      .reset       (reset),
      .parse_depth (parse_depth_ff),
      .hash_enable (hash_enable_ff),
      .head_valid  (head_valid),
      .head_ready  (head_ready),
      .head        (head),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

`default_nettype wire

>>> design/phfe_front.sv
// byte capture front end: picks header bytes out of the stream by position
`default_nettype none

module phfe_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [7:0]       req_tdata,
   input  wire logic             req_tlast,
   output logic                  push,
   output phfe_pkg::rec_type     push_rec,
   input  wire logic             push_ready
);

   phfe_pkg::rec_type cap_ff, cap_in;
   logic [7:0] pos;
   logic       vlan_seen;
   logic [15:0] mid_type;
   logic [4:0] ns;
   logic [8:0] ip_diff;
   logic       ip_hit;
   logic [4:0] ip_off;
   logic [3:0] ihl_eff;
   logic [6:0] l4;
   logic [8:0] l4_diff;
   logic       l4_hit;
   logic [3:0] l4_off;
   logic       accept;

   assign req_tready = push_ready;
   assign accept     = req_tvalid && req_tready;
   assign push       = accept && req_tlast;
   assign push_rec   = cap_in;

   always_comb begin
      cap_in   = cap_ff;
      pos      = cap_ff.byte_count;
      cap_in.byte_count = (pos == 8'hff) ? pos : pos + 8'd1;

      unique case (pos)
         8'd12: cap_in.type0[15:8] = req_tdata;
         8'd13: cap_in.type0[7:0]  = req_tdata;
         8'd14: cap_in.tag[11:8]   = req_tdata[3:0];
         8'd15: cap_in.tag[7:0]    = req_tdata;
         8'd16: cap_in.type1[15:8] = req_tdata;
         8'd17: cap_in.type1[7:0]  = req_tdata;
         8'd20: cap_in.ppp0[15:8]  = req_tdata;
         8'd21: cap_in.ppp0[7:0]   = req_tdata;
         8'd24: cap_in.ppp1[15:8]  = req_tdata;
         8'd25: cap_in.ppp1[7:0]   = req_tdata;
         default: ;
      endcase

      vlan_seen = (cap_ff.type0 == phfe_pkg::EthVlan);
      mid_type  = vlan_seen ? cap_ff.type1 : cap_ff.type0;
      ns        = 5'd14 + (vlan_seen ? 5'd4 : 5'd0)
                  + ((mid_type == phfe_pkg::EthPppoe) ? 5'd8 : 5'd0);

      ip_diff = {1'b0, pos} - {4'b0, ns};
      ip_hit  = !ip_diff[8] && (ip_diff[7:0] < 8'd20);
      ip_off  = ip_diff[4:0];

      if (ip_hit) begin
         unique case (ip_off)
            5'd0:  cap_in.ihl        = req_tdata[3:0];
            5'd6:  cap_in.frag[15:8] = req_tdata;
            5'd7:  cap_in.frag[7:0]  = req_tdata;
            5'd9:  cap_in.proto      = req_tdata;
            5'd12: cap_in.src[31:24] = req_tdata;
            5'd13: cap_in.src[23:16] = req_tdata;
            5'd14: cap_in.src[15:8]  = req_tdata;
            5'd15: cap_in.src[7:0]   = req_tdata;
            5'd16: cap_in.dst[31:24] = req_tdata;
            5'd17: cap_in.dst[23:16] = req_tdata;
            5'd18: cap_in.dst[15:8]  = req_tdata;
            5'd19: cap_in.dst[7:0]   = req_tdata;
            default: ;
         endcase
      end

      ihl_eff = (ip_hit && ip_off == 5'd0) ? req_tdata[3:0] : cap_ff.ihl;
      l4      = {2'b0, ns} + {1'b0, ihl_eff, 2'b0};
      l4_diff = {1'b0, pos} - {2'b0, l4};
      l4_hit  = !l4_diff[8] && (l4_diff[7:0] < 8'd14);
      l4_off  = l4_diff[3:0];

      if (l4_hit) begin
         unique case (l4_off)
            4'd0:  cap_in.sport[15:8] = req_tdata;
            4'd1:  cap_in.sport[7:0]  = req_tdata;
            4'd2:  cap_in.dport[15:8] = req_tdata;
            4'd3:  cap_in.dport[7:0]  = req_tdata;
            4'd12: cap_in.doff        = req_tdata[7:4];
            4'd13: cap_in.flags       = req_tdata[5:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= '0;
      end else if (accept) begin
         cap_ff <= req_tlast ? '0 : cap_in;
      end
   end

endmodule

`default_nettype wire

>>> design/phfe_queue.sv
// small queue of captured frame records between front and back
`default_nettype none

module phfe_queue #(
   parameter int unsigned DEPTH = phfe_pkg::QueueDepth
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire phfe_pkg::rec_type in_rec,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output phfe_pkg::rec_type      out_rec
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);
   localparam logic [CW-1:0] Full    = CW'(DEPTH);

   phfe_pkg::rec_type store [DEPTH];
   logic [AW-1:0] wr_ff, rd_ff;
   logic [CW-1:0] cnt_ff;
   logic          wr_en, rd_en;

   assign in_ready  = (cnt_ff != Full);
   assign out_valid = (cnt_ff != '0);
   assign out_rec   = store[rd_ff];
   assign wr_en     = in_valid && in_ready;
   assign rd_en     = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store[wr_ff] <= in_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (wr_en) begin
            wr_ff <= (wr_ff == LastIdx) ? '0 : wr_ff + AW'(1);
         end
         if (rd_en) begin
            rd_ff <= (rd_ff == LastIdx) ? '0 : rd_ff + AW'(1);
         end
         if (wr_en && !rd_en) begin
            cnt_ff <= cnt_ff + CW'(1);
         end else if (rd_en && !wr_en) begin
            cnt_ff <= cnt_ff - CW'(1);
         end
      end
   end

endmodule

`default_nettype wire

>>> design/phfe_back.sv
// back end: header decode, flow hash and output register
`default_nettype none

module phfe_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [2:0]        parse_depth,
   input  wire logic              hash_enable,
   input  wire logic              head_valid,
   output logic                   head_ready,
   input  wire phfe_pkg::rec_type head,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [phfe_pkg::RspWidth-1:0] rsp_tdata
);

   phfe_pkg::dec_type dec, s1_ff;
   logic        s1_valid_ff, o_valid_ff;
   logic [phfe_pkg::RspWidth-1:0] o_data_ff, o_data_in;
   logic        out_free, s1_free;
   logic        vlan_seen, ip_ok, depth3, depth4;
   logic [15:0] pppw;
   logic [4:0]  ns;
   logic [8:0]  cnt;
   logic [6:0]  l4;
   logic [31:0] hash;

   assign out_free   = !o_valid_ff || rsp_tready;
   assign s1_free    = !s1_valid_ff || out_free;
   assign head_ready = s1_free;
   assign rsp_tvalid = o_valid_ff;
   assign rsp_tdata  = o_data_ff;

   assign depth3 = (parse_depth >= 3'd3);
   assign depth4 = (parse_depth >= 3'd4);

   always_comb begin
      dec       = '0;
      cnt       = {1'b0, head.byte_count};
      vlan_seen = (head.type0 == phfe_pkg::EthVlan);
      dec.vlan  = vlan_seen ? head.tag : 12'd0;
      dec.etype = vlan_seen ? head.type1 : head.type0;
      pppw      = vlan_seen ? head.ppp1 : head.ppp0;
      ns        = 5'd14 + (vlan_seen ? 5'd4 : 5'd0)
                  + ((dec.etype == phfe_pkg::EthPppoe) ? 5'd8 : 5'd0);
      if (dec.etype == phfe_pkg::EthPppoe && pppw == phfe_pkg::PppIpv4) begin
         dec.etype = phfe_pkg::EthIpv4;
      end
      dec.depth = phfe_pkg::DepthLink;
      l4        = {2'b0, ns} + {1'b0, head.ihl, 2'b0};
      ip_ok     = depth3 && (dec.etype == phfe_pkg::EthIpv4)
                  && (cnt >= {4'b0, ns} + 9'd20);
      if (ip_ok) begin
         dec.proto = head.proto;
         dec.src   = head.src;
         dec.dst   = head.dst;
         if ((head.frag & phfe_pkg::FragMask) == 16'd0) begin
            dec.l4    = {1'b0, l4};
            dec.depth = phfe_pkg::DepthNet;
            if (depth4) begin
               if (head.proto == phfe_pkg::ProtoTcp) begin
                  if (cnt >= {2'b0, l4} + 9'd20) begin
                     dec.sport   = head.sport;
                     dec.dport   = head.dport;
                     dec.flags   = head.flags;
                     dec.payload = {1'b0, l4} + {2'b0, head.doff, 2'b0};
                     dec.depth   = phfe_pkg::DepthXport;
                  end
               end else if (head.proto == phfe_pkg::ProtoUdp) begin
                  if (cnt >= {2'b0, l4} + 9'd8) begin
                     dec.sport   = head.sport;
                     dec.dport   = head.dport;
                     dec.payload = {1'b0, l4} + 8'd8;
                     dec.depth   = phfe_pkg::DepthXport;
                  end
               end else begin
                  dec.payload = {1'b0, l4};
                  dec.depth   = phfe_pkg::DepthXport;
               end
            end
         end
      end
      dec.small_sum = {6'b0, dec.vlan} + {10'b0, dec.proto}
                      + {2'b0, dec.sport} + {2'b0, dec.dport};
      dec.hash_en   = hash_enable;
   end

   always_comb begin
      hash = s1_ff.hash_en ? (s1_ff.src + s1_ff.dst + {14'b0, s1_ff.small_sum}) : 32'd0;
      o_data_in = {3'b0, hash, s1_ff.flags, s1_ff.payload, s1_ff.l4, s1_ff.dport,
                   s1_ff.sport, s1_ff.dst, s1_ff.src, s1_ff.proto, s1_ff.vlan,
                   s1_ff.etype, s1_ff.depth};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         o_valid_ff  <= 1'b0;
      end else begin
         if (s1_free) begin
            s1_valid_ff <= head_valid;
         end
         if (out_free) begin
            o_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_free && head_valid) begin
         s1_ff <= dec;
      end
      if (out_free && s1_valid_ff) begin
         o_data_ff <= o_data_in;
      end
   end

endmodule

`default_nettype wire

>>> design/phfe_checker.sv
// port-level checks of the packet header field extractor, bound to the top
`default_nettype none

module phfe_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic rsp_tvalid,
   input wire logic rsp_tready,
   input wire logic [phfe_pkg::RspWidth-1:0] rsp_tdata
);

   logic [2:0] depth;
   logic       upper_zero;
   logic       l4_zero;

   assign depth      = rsp_tdata[2:0];
   assign upper_zero = (rsp_tdata[150:143] == 8'd0) && (rsp_tdata[134:103] == 32'd0)
                       && (rsp_tdata[156:151] == 6'd0);
   assign l4_zero    = (rsp_tdata[142:135] == 8'd0);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped or changed while stalled");

   a_depth_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (depth == phfe_pkg::DepthLink) || (depth == phfe_pkg::DepthNet)
                     || (depth == phfe_pkg::DepthXport))
      else $error("depth out of range");

   a_link_only: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && depth == phfe_pkg::DepthLink |-> l4_zero && upper_zero)
      else $error("transport fields set at link depth");

   a_net_only: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && depth == phfe_pkg::DepthNet |-> upper_zero)
      else $error("transport fields set at network depth");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind packet_header_field_extractor phfe_checker u_phfe_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

>>> bench/packet_header_field_extractor_test.sv
// testbench of the packet header field extractor: random and directed frames checked against a predictor
`timescale 1ns / 100ps

module packet_header_field_extractor_test;

   typedef struct packed {
      logic [2:0]  pad;
      logic [31:0] flow_hash;
      logic [5:0]  tcp_flags;
      logic [7:0]  payload_start;
      logic [7:0]  transport_offset;
      logic [15:0] dest_port;
      logic [15:0] source_port;
      logic [31:0] dest_address;
      logic [31:0] source_address;
      logic [7:0]  ip_protocol;
      logic [11:0] vlan_id;
      logic [15:0] ether_type;
      logic [2:0]  depth;
   } header_fields_type;

   class header_scoreboard_type;
      logic [7:0]        frame_mem [128];
      int unsigned       byte_count;
      logic [2:0]        depth_limit;
      bit                hash_on;
      header_fields_type pending [$];
      int                errors;

      function new();
         foreach (frame_mem[i]) frame_mem[i] = 8'h00;
         byte_count = 0;
         depth_limit = phfe_pkg::DepthXport;
         hash_on = 1'b1;
         errors = 0;
      endfunction

      function logic [7:0] byte_at(int unsigned i);
         return (i < 128) ? frame_mem[i] : 8'h00;
      endfunction

      function logic [15:0] word_at(int unsigned i);
         return {byte_at(i), byte_at(i + 1)};
      endfunction

      function void note_byte(logic [7:0] value, bit last);
         header_fields_type f;
         int unsigned caplen, shift, pppoe, ns, l4, payload, doff;
         logic [15:0] etype;
         logic [7:0]  b;
         shift = 0;
         pppoe = 0;
         l4 = 0;
         payload = 0;
         if (byte_count < 128) frame_mem[byte_count] = value;
         if (byte_count < 255) byte_count++;
         if (!last) return;
         caplen = byte_count;
         f = '0;
         f.depth = phfe_pkg::DepthLink;
         etype = word_at(12);
         if (etype == phfe_pkg::EthVlan) begin
            b = byte_at(14);
            f.vlan_id = {b[3:0], byte_at(15)};
            etype = word_at(16);
            shift = 4;
         end
         if (etype == phfe_pkg::EthPppoe) begin
            if (word_at(20 + shift) == phfe_pkg::PppIpv4) etype = phfe_pkg::EthIpv4;
            pppoe = 8;
         end
         f.ether_type = etype;
         ns = 14 + shift + pppoe;
         if (depth_limit >= 3 && etype == phfe_pkg::EthIpv4 && caplen >= ns + 20) begin
            f.ip_protocol = byte_at(ns + 9);
            f.source_address = {word_at(ns + 12), word_at(ns + 14)};
            f.dest_address = {word_at(ns + 16), word_at(ns + 18)};
            if ((word_at(ns + 6) & phfe_pkg::FragMask) == 16'h0) begin
               b = byte_at(ns);
               l4 = ns + 4 * 32'(b[3:0]);
               f.depth = phfe_pkg::DepthNet;
               if (depth_limit >= 4) begin
                  if (f.ip_protocol == phfe_pkg::ProtoTcp) begin
                     if (caplen >= l4 + 20) begin
                        f.source_port = word_at(l4);
                        f.dest_port = word_at(l4 + 2);
                        doff = 32'(byte_at(l4 + 12) >> 4);
                        b = byte_at(l4 + 13);
                        f.tcp_flags = b[5:0];
                        payload = l4 + doff * 4;
                        f.depth = phfe_pkg::DepthXport;
                     end
                  end else if (f.ip_protocol == phfe_pkg::ProtoUdp) begin
                     if (caplen >= l4 + 8) begin
                        f.source_port = word_at(l4);
                        f.dest_port = word_at(l4 + 2);
                        payload = l4 + 8;
                        f.depth = phfe_pkg::DepthXport;
                     end
                  end else begin
                     payload = l4;
                     f.depth = phfe_pkg::DepthXport;
                  end
               end
            end
         end
         f.transport_offset = l4[7:0];
         f.payload_start = payload[7:0];
         if (hash_on)
            f.flow_hash = 32'(f.vlan_id) + 32'(f.ip_protocol) + f.source_address
                        + f.dest_address + 32'(f.source_port) + 32'(f.dest_port);
         pending.push_back(f);
         foreach (frame_mem[i]) frame_mem[i] = 8'h00;
         byte_count = 0;
      endfunction

      function void field_check(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            errors++;
            if (errors <= 10)
               $display("mismatch %s: expected %h actual %h", name, want, got);
         end
      endfunction

      function void check_result(header_fields_type got);
         header_fields_type want;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result transaction %h", got);
            return;
         end
         want = pending.pop_front();
         field_check("depth", want.depth, got.depth);
         field_check("ether_type", want.ether_type, got.ether_type);
         field_check("vlan_id", want.vlan_id, got.vlan_id);
         field_check("ip_protocol", want.ip_protocol, got.ip_protocol);
         field_check("source_address", want.source_address, got.source_address);
         field_check("dest_address", want.dest_address, got.dest_address);
         field_check("source_port", want.source_port, got.source_port);
         field_check("dest_port", want.dest_port, got.dest_port);
         field_check("transport_offset", want.transport_offset, got.transport_offset);
         field_check("payload_start", want.payload_start, got.payload_start);
         field_check("tcp_flags", want.tcp_flags, got.tcp_flags);
         field_check("flow_hash", want.flow_hash, got.flow_hash);
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [7:0]          req_tdata;   // packet_byte
   logic                req_tlast;
   logic                rsp_tvalid;
   logic                rsp_tready;
   // depth_reached, ether_type, vlan_tag_id, ip_protocol, source_address,
   // dest_address, source_port, dest_port, transport_offset, payload_start,
   // tcp_flag_bits, flow_hash, zero fill
   logic [phfe_pkg::RspWidth-1:0] rsp_tdata;
   logic                csr_psel;
   logic                csr_penable;
   logic                csr_pwrite;
   logic [2:0]          csr_paddr;
   logic [31:0]         csr_pwdata;
   logic [31:0]         csr_prdata;
   logic                csr_pready;

   header_scoreboard_type header_sb;
   logic [7:0]            frame_q [$];
   bit                    calm;
   bit                    hold_request;

   packet_header_field_extractor u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   initial begin
      #4_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // receiver side
   initial begin
      int unsigned hold;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold = 80;
         end
         if (hold > 0) begin
            hold--;
            rsp_tready = 1'b0;
         end else begin
            rsp_tready = calm ? 1'b1 : ($urandom_range(99) >= 37);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         header_sb.check_result(header_fields_type'(rsp_tdata));
   end

   task automatic send_byte(logic [7:0] value, bit last);
      @(negedge clock);
      while (!calm && $urandom_range(99) < 37) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = value;
      req_tlast = last;
      do @(posedge clock); while (!req_tready);
      header_sb.note_byte(value, last);
   endtask

   task automatic send_frame();
      foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
      frame_q.delete();
   endtask

   task automatic push_random(int unsigned n);
      repeat (n) frame_q.push_back(8'($urandom));
   endtask

   task automatic push_word(logic [15:0] w);
      frame_q.push_back(w[15:8]);
      frame_q.push_back(w[7:0]);
   endtask

   // encap: 0 plain, 1 vlan, 2 pppoe, 3 vlan and pppoe, 4 random type
   // transport: 0 tcp, 1 udp, 2 random protocol
   task automatic make_frame(int encap, int transport, int ihl, bit frag, bit bad_ppp,
                             int tail, int cut);
      push_random(12);
      if (encap == 1 || encap == 3) begin
         push_word(phfe_pkg::EthVlan);
         push_random(2);
      end
      if (encap == 4) begin
         push_random(2);
         push_random(60);
      end else begin
         if (encap >= 2) begin
            push_word(phfe_pkg::EthPppoe);
            push_random(6);
            push_word(bad_ppp ? 16'($urandom) : phfe_pkg::PppIpv4);
         end else begin
            push_word(phfe_pkg::EthIpv4);
         end
         frame_q.push_back({4'h4, 4'(ihl)});
         push_random(5);
         push_word(frag ? 16'($urandom_range(16'hffff, 1)) : {3'($urandom), 13'h0} & 16'hc000);
         push_random(1);
         frame_q.push_back(transport == 0 ? phfe_pkg::ProtoTcp
                           : transport == 1 ? phfe_pkg::ProtoUdp : 8'($urandom));
         push_random(10);
         if (ihl > 5) push_random((ihl - 5) * 4);
         push_random(transport == 0 ? 20 : transport == 1 ? 8 : 4);
      end
      push_random(tail);
      if (cut > 0) while (frame_q.size() > cut) void'(frame_q.pop_back());
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (header_sb.pending.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] index, logic [31:0] value);
      @(negedge clock);
      csr_psel = 1'b1;
      csr_pwrite = 1'b1;
      csr_penable = 1'b0;
      csr_paddr = {index[0], 2'b00};
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      if (index == phfe_pkg::RegParseDepth) header_sb.depth_limit = value[2:0];
      else header_sb.hash_on = value[0];
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
   endtask

   initial begin
      header_sb = new();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = 8'h00;
      req_tlast = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      calm = 1'b0;
      hold_request = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed frames at reset settings
      push_random(1);
      send_frame();
      make_frame(0, 0, 5, 0, 0, 0, 0);
      send_frame();
      make_frame(3, 1, 5, 0, 0, 0, 0);
      send_frame();
      make_frame(0, 0, 5, 1, 0, 0, 0);
      send_frame();
      make_frame(0, 0, 3, 0, 0, 0, 45);
      send_frame();
      make_frame(0, 0, 5, 0, 0, 0, 25);
      send_frame();
      make_frame(0, 0, 15, 0, 0, 170, 0);
      send_frame();
      // fill the block while the receiver holds off
      calm = 1'b1;
      hold_request = 1'b1;
      repeat (16) begin
         push_random(1);
         send_frame();
      end
      calm = 1'b0;
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: write_reg(phfe_pkg::RegParseDepth, 32'd2);
            1: write_reg(phfe_pkg::RegHashEnable, 32'd0);
            2: write_reg(phfe_pkg::RegParseDepth, 32'd3);
            3: write_reg(phfe_pkg::RegHashEnable, 32'd1);
            4: write_reg(phfe_pkg::RegParseDepth, 32'd4);
            default: write_reg(phfe_pkg::RegParseDepth, 32'd4);
         endcase
         calm = (phase == 4);
         if ($urandom_range(9) == 0) push_random($urandom_range(40, 1));
         else make_frame($urandom_range(9) < 6 ? $urandom_range(3) : 4,
                         $urandom_range(2),
                         $urandom_range(9) < 7 ? 5 : $urandom_range(15),
                         $urandom_range(9) == 0, $urandom_range(9) == 0,
                         $urandom_range(8),
                         $urandom_range(3) == 0 ? $urandom_range(70, 1) : 0);
         send_frame();
         calm = 1'b0;
         drain();
      end

      if (header_sb.errors == 0 && header_sb.pending.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

>>> files.f
design/phfe_pkg.sv
design/phfe_front.sv
design/phfe_queue.sv
design/phfe_back.sv
design/packet_header_field_extractor.sv
design/phfe_checker.sv
bench/packet_header_field_extractor_test.sv
